FILE: design/dlcr_pkg.sv
// ----------------------------------------------------------------------------
// dlcr_pkg: shared definitions for the line color rasterizer
// Default parameter values, fixed field widths, item kinds, the sequencer
// states and the divider operation codes.
// ----------------------------------------------------------------------------
package dlcr_pkg;

  localparam int COORD_INT_BITS_DEF  = 12;
  localparam int COORD_FRAC_BITS_DEF = 4;
  localparam int STEP_FRAC_BITS_DEF  = 20;
  localparam int COORD_W_DEF         = COORD_INT_BITS_DEF + COORD_FRAC_BITS_DEF;

  localparam int PIX_W   = 12;
  localparam int CH_W    = 8;
  localparam int NUM_CH  = 3;
  localparam int COLOR_W = CH_W * NUM_CH;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_LINE
  } state_t;

  // Divider jobs after a start, in order: x step, y step, then the three
  // color channels from the low byte up.
  typedef enum logic [2:0] {
    OP_DX,
    OP_DY,
    OP_C0,
    OP_C1,
    OP_C2
  } div_op_t;

endpackage

FILE: design/dlcr_channels.sv
// ----------------------------------------------------------------------------
// dlcr channels: valid/ready interfaces of the line color rasterizer
// The input channel carries line starts and ticks, the output channel
// carries one pixel per transfer.
// ----------------------------------------------------------------------------
interface dlcr_in_if #(
  parameter int COORD_W = dlcr_pkg::COORD_W_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic signed [COORD_W-1:0]     start_x;
  logic signed [COORD_W-1:0]     start_y;
  logic signed [COORD_W-1:0]     end_x;
  logic signed [COORD_W-1:0]     end_y;
  logic [dlcr_pkg::COLOR_W-1:0]  start_color;
  logic [dlcr_pkg::COLOR_W-1:0]  end_color;

  modport source (
    output valid, kind, start_x, start_y, end_x, end_y, start_color, end_color,
    input  ready
  );
  modport sink (
    input  valid, kind, start_x, start_y, end_x, end_y, start_color, end_color,
    output ready
  );
endinterface

interface dlcr_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [dlcr_pkg::PIX_W-1:0]   pixel_x;
  logic signed [dlcr_pkg::PIX_W-1:0]   pixel_y;
  logic [dlcr_pkg::COLOR_W-1:0]        pixel_color;
  logic                                last;

  modport source (
    output valid, pixel_x, pixel_y, pixel_color, last,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, pixel_color, last,
    output ready
  );
endinterface

FILE: design/dda_line_color_raster_top.sv
// ----------------------------------------------------------------------------
// dda_line_color_raster_top: DDA line rasterizer with a color gradient
// A start transfer on in_ch loads two endpoints and two RGB colors and emits
// the first pixel; each tick transfer emits the next pixel on out_ch, the
// final pixel carrying last. Pixel colors are linear blends of the end colors.
//
// Usage and timing:
// - A start's first pixel appears in the output register on the next cycle
//   after the start is taken.
// - For a line of nonzero length, one shared restoring divider then works out
//   the x and y steps and then the three color slopes, one after another;
//   during this work in_ch.ready stays low.
// - After that, back-to-back ticks run at one pixel per cycle while out_ch.ready
//   stays high; per-channel remainder accumulators replace a divide.
// - A start abandons any line in progress. A tick with no line in progress is
//   taken and produces no pixel. A zero-length line gives one pixel at once.
// - The output register holds a pixel until its transfer; while it is full and
//   out_ch.ready is low, in_ch.ready is low too.
// - Reset returns the block to idle with an empty output register.
// ----------------------------------------------------------------------------
module dda_line_color_raster_top #(
  parameter int COORD_INT_BITS  = dlcr_pkg::COORD_INT_BITS_DEF,
  parameter int COORD_FRAC_BITS = dlcr_pkg::COORD_FRAC_BITS_DEF,
  parameter int STEP_FRAC_BITS  = dlcr_pkg::STEP_FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  dlcr_in_if.sink       in_ch,
  dlcr_out_if.source    out_ch
);

  localparam int CI      = COORD_INT_BITS;
  localparam int CF      = COORD_FRAC_BITS;
  localparam int SF      = STEP_FRAC_BITS;
  localparam int CW      = CI + CF;
  localparam int SH      = SF - CF;
  localparam int MAG_W   = CW + SH;
  localparam int STEP_W  = SF + 2;
  localparam int POS_W   = CI + SF + 1;
  localparam int CNT_W   = $clog2(MAG_W + 1);
  localparam int PIX_W   = dlcr_pkg::PIX_W;
  localparam int CH_W    = dlcr_pkg::CH_W;
  localparam int NUM_CH  = dlcr_pkg::NUM_CH;
  localparam int COLOR_W = dlcr_pkg::COLOR_W;
  localparam int CH_SEL_W = $clog2(NUM_CH);

  // Position in pixels, truncated toward zero, low PIX_W bits.
  function automatic logic [PIX_W-1:0] to_pixel(input logic [POS_W-1:0] p);
    logic [POS_W-1:0] q;
    logic             adj;
    q   = $signed(p) >>> SF;
    adj = p[POS_W-1] && (p[SF-1:0] != '0);
    return q[PIX_W-1:0] + {{(PIX_W-1){1'b0}}, adj};
  endfunction

  dlcr_pkg::state_t  state_r, state_nxt;
  dlcr_pkg::div_op_t op_r;

  // Line state
  logic [POS_W-1:0]   pos_x_r, pos_y_r;
  logic [STEP_W-1:0]  step_x_r, step_y_r;
  logic [CI-1:0]      pixel_index_r, step_total_r;
  logic [COLOR_W-1:0] color_from_r, color_to_r;
  logic [CW-1:0]      dx_mag_r, dy_mag_r;
  logic               dx_neg_r, dy_neg_r;
  logic [CH_W-1:0]    q0_r    [NUM_CH];
  logic [CI-1:0]      r0_r    [NUM_CH];
  logic [CH_W-1:0]    acc_q_r [NUM_CH];
  logic [CI-1:0]      acc_r_r [NUM_CH];

  // Shared divider
  logic [MAG_W-1:0]   div_q_r;
  logic [CI-1:0]      div_rem_r;
  logic [CNT_W-1:0]   div_cnt_r;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]   pix_x_r, pix_y_r;
  logic [COLOR_W-1:0] pix_color_r;
  logic               pix_last_r;

  // Combinational signals
  logic               in_ready_w, in_xfer_w, start_w, tick_w, last_tick_w;
  logic [CW:0]        dx_w, dy_w;
  logic [CW-1:0]      dx_abs_w, dy_abs_w, mx_w;
  logic [CI-1:0]      dt_w;
  logic [POS_W-1:0]   pos_x_init_w, pos_y_init_w;
  logic [CH_W-1:0]    cmag_w [NUM_CH];
  logic               cneg_w [NUM_CH];
  logic [COLOR_W-1:0] tick_color_w;
  logic [CH_W-1:0]    acc_q_nxt [NUM_CH];
  logic [CI-1:0]      acc_r_nxt [NUM_CH];
  logic [CI:0]        r_sum_w   [NUM_CH];
  logic [CI:0]        r_sub_w   [NUM_CH];
  logic [CI:0]        rem_sh_w, rem_sub_w;
  logic               div_ge_w, div_done_w;
  logic [CI-1:0]      rem_step_w;
  logic [MAG_W-1:0]   q_step_w, load_dvd_w;
  logic [CNT_W-1:0]   load_cnt_w;
  logic               op_is_color_w;
  logic [CH_SEL_W-1:0] ch_sel_w;
  logic [STEP_W-1:0]  step_res_w;
  logic [POS_W-1:0]   step_res_ext_w;
  logic [POS_W-1:0]   step_x_ext_w, step_y_ext_w;

  // Start decode: deltas, dominant axis length and starting positions
  always_comb begin
    dx_w = {in_ch.end_x[CW-1], in_ch.end_x} - {in_ch.start_x[CW-1], in_ch.start_x};
    dy_w = {in_ch.end_y[CW-1], in_ch.end_y} - {in_ch.start_y[CW-1], in_ch.start_y};
    dx_abs_w = dx_w[CW] ? (~dx_w[CW-1:0] + 1'b1) : dx_w[CW-1:0];
    dy_abs_w = dy_w[CW] ? (~dy_w[CW-1:0] + 1'b1) : dy_w[CW-1:0];
    mx_w = (dx_abs_w > dy_abs_w) ? dx_abs_w : dy_abs_w;
    dt_w = mx_w[CW-1:CF];
    pos_x_init_w = {{(POS_W-CW-SH){in_ch.start_x[CW-1]}}, in_ch.start_x, {SH{1'b0}}};
    pos_y_init_w = {{(POS_W-CW-SH){in_ch.start_y[CW-1]}}, in_ch.start_y, {SH{1'b0}}};
  end

  // Color channels: slope magnitude and direction, tick color, accumulator
  // advance. The remainder stays below dt, so one compare and subtract is
  // enough for each pixel.
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      cneg_w[ch] = color_to_r[ch*CH_W +: CH_W] < color_from_r[ch*CH_W +: CH_W];
      cmag_w[ch] = cneg_w[ch]
                 ? color_from_r[ch*CH_W +: CH_W] - color_to_r[ch*CH_W +: CH_W]
                 : color_to_r[ch*CH_W +: CH_W] - color_from_r[ch*CH_W +: CH_W];
      tick_color_w[ch*CH_W +: CH_W] = cneg_w[ch]
                 ? color_from_r[ch*CH_W +: CH_W] - acc_q_r[ch]
                 : color_from_r[ch*CH_W +: CH_W] + acc_q_r[ch];
      r_sum_w[ch] = {1'b0, acc_r_r[ch]} + {1'b0, r0_r[ch]};
      r_sub_w[ch] = r_sum_w[ch] - {1'b0, step_total_r};
      if (r_sum_w[ch] >= {1'b0, step_total_r}) begin
        acc_r_nxt[ch] = r_sub_w[ch][CI-1:0];
        acc_q_nxt[ch] = acc_q_r[ch] + q0_r[ch] + 1'b1;
      end else begin
        acc_r_nxt[ch] = r_sum_w[ch][CI-1:0];
        acc_q_nxt[ch] = acc_q_r[ch] + q0_r[ch];
      end
    end
  end

  // Shared divider step and job selection
  always_comb begin
    rem_sh_w   = {div_rem_r, div_q_r[MAG_W-1]};
    rem_sub_w  = rem_sh_w - {1'b0, step_total_r};
    div_ge_w   = rem_sh_w >= {1'b0, step_total_r};
    rem_step_w = div_ge_w ? rem_sub_w[CI-1:0] : rem_sh_w[CI-1:0];
    q_step_w   = {div_q_r[MAG_W-2:0], div_ge_w};
    div_done_w = (state_r == dlcr_pkg::S_DIV) && (div_cnt_r == CNT_W'(1));

    load_dvd_w    = '0;
    load_cnt_w    = CNT_W'(MAG_W);
    op_is_color_w = 1'b0;
    ch_sel_w      = '0;
    unique case (op_r)
      dlcr_pkg::OP_DX: begin
        load_dvd_w = {dx_mag_r, {SH{1'b0}}};
      end
      dlcr_pkg::OP_DY: begin
        load_dvd_w = {dy_mag_r, {SH{1'b0}}};
      end
      dlcr_pkg::OP_C0: begin
        op_is_color_w = 1'b1;
        ch_sel_w      = CH_SEL_W'(0);
      end
      dlcr_pkg::OP_C1: begin
        op_is_color_w = 1'b1;
        ch_sel_w      = CH_SEL_W'(1);
      end
      dlcr_pkg::OP_C2: begin
        op_is_color_w = 1'b1;
        ch_sel_w      = CH_SEL_W'(2);
      end
      default: begin
        op_is_color_w = 1'b0;
      end
    endcase
    if (op_is_color_w) begin
      load_dvd_w = {cmag_w[ch_sel_w], {(MAG_W-CH_W){1'b0}}};
      load_cnt_w = CNT_W'(CH_W);
    end

    // Quotient magnitude of a step is below 2^(SF+1), so it fits STEP_W bits.
    if (op_r == dlcr_pkg::OP_DX) begin
      step_res_w = dx_neg_r ? (~q_step_w[STEP_W-1:0] + 1'b1) : q_step_w[STEP_W-1:0];
    end else begin
      step_res_w = dy_neg_r ? (~q_step_w[STEP_W-1:0] + 1'b1) : q_step_w[STEP_W-1:0];
    end
    step_res_ext_w = {{(POS_W-STEP_W){step_res_w[STEP_W-1]}}, step_res_w};
    step_x_ext_w   = {{(POS_W-STEP_W){step_x_r[STEP_W-1]}}, step_x_r};
    step_y_ext_w   = {{(POS_W-STEP_W){step_y_r[STEP_W-1]}}, step_y_r};
  end

  // Sequencer and handshake
  always_comb begin
    in_ready_w  = rst_n && (state_r != dlcr_pkg::S_DIV) && (!out_valid_r || out_ch.ready);
    in_xfer_w   = in_ch.valid && in_ready_w;
    start_w     = in_xfer_w && (in_ch.kind == dlcr_pkg::KIND_START);
    tick_w      = in_xfer_w && (in_ch.kind == dlcr_pkg::KIND_TICK)
                  && (state_r == dlcr_pkg::S_LINE);
    last_tick_w = pixel_index_r >= step_total_r;

    if (start_w || tick_w) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end

    state_nxt = state_r;
    unique case (state_r)
      dlcr_pkg::S_IDLE, dlcr_pkg::S_LINE: begin
        if (start_w) begin
          state_nxt = (dt_w == '0) ? dlcr_pkg::S_IDLE : dlcr_pkg::S_DIV;
        end else if (tick_w && last_tick_w) begin
          state_nxt = dlcr_pkg::S_IDLE;
        end
      end
      dlcr_pkg::S_DIV: begin
        if (div_done_w && (op_r == dlcr_pkg::OP_C2)) begin
          state_nxt = dlcr_pkg::S_LINE;
        end
      end
      default: begin
        state_nxt = dlcr_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dlcr_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      op_r        <= dlcr_pkg::OP_DX;
      div_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (start_w) begin
        op_r      <= dlcr_pkg::OP_DX;
        div_cnt_r <= '0;
      end else if (state_r == dlcr_pkg::S_DIV) begin
        if (div_cnt_r == '0) begin
          div_cnt_r <= load_cnt_w;
        end else begin
          div_cnt_r <= div_cnt_r - 1'b1;
          if (div_done_w && (op_r != dlcr_pkg::OP_C2)) begin
            op_r <= dlcr_pkg::div_op_t'(op_r + 3'd1);
          end
        end
      end
    end
  end

  // Datapath and output payload
  always_ff @(posedge clk) begin
    if (start_w) begin
      color_from_r  <= in_ch.start_color;
      color_to_r    <= in_ch.end_color;
      step_total_r  <= dt_w;
      pos_x_r       <= pos_x_init_w;
      pos_y_r       <= pos_y_init_w;
      pixel_index_r <= CI'(1);
      dx_mag_r      <= dx_abs_w;
      dy_mag_r      <= dy_abs_w;
      dx_neg_r      <= dx_w[CW];
      dy_neg_r      <= dy_w[CW];
      pix_x_r       <= to_pixel(pos_x_init_w);
      pix_y_r       <= to_pixel(pos_y_init_w);
      pix_color_r   <= in_ch.start_color;
      pix_last_r    <= (dt_w == '0);
    end else if (tick_w) begin
      pix_x_r     <= to_pixel(pos_x_r);
      pix_y_r     <= to_pixel(pos_y_r);
      pix_color_r <= tick_color_w;
      pix_last_r  <= last_tick_w;
      if (!last_tick_w) begin
        pixel_index_r <= pixel_index_r + 1'b1;
        pos_x_r       <= pos_x_r + step_x_ext_w;
        pos_y_r       <= pos_y_r + step_y_ext_w;
        for (int ch = 0; ch < NUM_CH; ch++) begin
          acc_q_r[ch] <= acc_q_nxt[ch];
          acc_r_r[ch] <= acc_r_nxt[ch];
        end
      end
    end else if (state_r == dlcr_pkg::S_DIV) begin
      if (div_cnt_r == '0) begin
        div_q_r   <= load_dvd_w;
        div_rem_r <= '0;
      end else begin
        div_q_r   <= q_step_w;
        div_rem_r <= rem_step_w;
        // On the final step the results go to the line state; the position
        // moves to the second pixel once its step is known.
        if (div_done_w) begin
          if (op_is_color_w) begin
            q0_r[ch_sel_w]    <= q_step_w[CH_W-1:0];
            r0_r[ch_sel_w]    <= rem_step_w;
            acc_q_r[ch_sel_w] <= q_step_w[CH_W-1:0];
            acc_r_r[ch_sel_w] <= rem_step_w;
          end else if (op_r == dlcr_pkg::OP_DX) begin
            step_x_r <= step_res_w;
            pos_x_r  <= pos_x_r + step_res_ext_w;
          end else begin
            step_y_r <= step_res_w;
            pos_y_r  <= pos_y_r + step_res_ext_w;
          end
        end
      end
    end
  end

  assign in_ch.ready        = in_ready_w;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.pixel_x     = pix_x_r;
  assign out_ch.pixel_y     = pix_y_r;
  assign out_ch.pixel_color = pix_color_r;
  assign out_ch.last        = pix_last_r;

endmodule
